// ----- src/ect_pkg.sv -----
package ect_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_UP    = 2'd1,
      KIND_DOWN  = 2'd2,
      KIND_START = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      DIGIT_NONE     = 2'd0,
      DIGIT_ONES     = 2'd1,
      DIGIT_TENS     = 2'd2,
      DIGIT_HUNDREDS = 2'd3
   } digit_sel_type;

   typedef enum logic {
      CSR_TICKS_PER_SECOND = 1'b0,
      CSR_MAX_SECONDS      = 1'b1
   } csr_index_type;

   localparam int KindWidth    = 2;
   localparam int TickWidth    = 16;
   localparam int SecondsWidth = 10;
   localparam int SegWidth     = 7;
   localparam int CsrDataWidth = 16;
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 24;

   localparam logic [SecondsWidth-1:0] SECONDS_CAP   = 10'd999;
   localparam logic [SecondsWidth-1:0] RESET_SECONDS = 10'd30;
   localparam logic [TickWidth-1:0]    RESET_TICKS   = 16'd1000;

   typedef struct packed {
      logic                    relay_on;
      logic [SegWidth-1:0]     segments;
      digit_sel_type           digit_enable;
      logic [SecondsWidth-1:0] seconds_left;
   } result_type;

   function automatic logic [SegWidth-1:0] seg_decode(input logic [3:0] digit);
      logic [SegWidth-1:0] seg;
      case (digit)
         4'd0: seg = 7'h3F;
         4'd1: seg = 7'h06;
         4'd2: seg = 7'h5B;
         4'd3: seg = 7'h4F;
         4'd4: seg = 7'h66;
         4'd5: seg = 7'h6D;
         4'd6: seg = 7'h7D;
         4'd7: seg = 7'h07;
         4'd8: seg = 7'h7F;
         4'd9: seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

// ----- src/ect_digits.sv -----
module ect_digits (
   input  logic [ect_pkg::SecondsWidth-1:0] value,
   input  ect_pkg::digit_sel_type           pos,
   output logic [ect_pkg::SegWidth-1:0]     segments
);
   import ect_pkg::*;

   // Constant-reciprocal division: v*205>>11 = v/10, v*41>>12 = v/100 for v < 1024.
   logic [17:0] prod10;
   logic [15:0] prod100;
   logic [6:0]  quot10;
   logic [3:0]  quot100;
   logic [3:0]  ones;
   logic [3:0]  tens;
   logic [3:0]  digit;
   logic [SecondsWidth-1:0] tens_x10;
   logic [6:0]  hund_x10;

   always_comb begin
      prod10   = 18'(value) * 18'd205;
      prod100  = 16'(value) * 16'd41;
      quot10   = prod10[17:11];
      quot100  = prod100[15:12];
      tens_x10 = SecondsWidth'(quot10) * SecondsWidth'(10);
      hund_x10 = 7'(quot100) * 7'd10;
      ones     = 4'(value - tens_x10);
      tens     = 4'(quot10 - hund_x10);
      case (pos)
         DIGIT_ONES:     digit = ones;
         DIGIT_TENS:     digit = tens;
         DIGIT_HUNDREDS: digit = quot100;
         default:        digit = ones;
      endcase
      segments = seg_decode(digit);
   end

endmodule

// ----- src/ect_state.sv -----
module ect_state (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  ect_pkg::csr_index_type           csr_index,
   input  logic [ect_pkg::CsrDataWidth-1:0] csr_wdata,
   input  logic                             step,
   input  ect_pkg::event_kind_type          kind,
   output ect_pkg::result_type              result
);
   import ect_pkg::*;

   logic [TickWidth-1:0]    ticks_per_second_ff, ticks_per_second_in;
   logic [SecondsWidth-1:0] max_seconds_ff, max_seconds_in;
   logic [SecondsWidth-1:0] seconds_ff, seconds_in;
   logic                    running_ff, running_in;
   logic [TickWidth-1:0]    tick_count_ff, tick_count_in;
   digit_sel_type           position_ff, position_in;
   logic [SegWidth-1:0]     shown_seg_ff, shown_seg_in;
   digit_sel_type           shown_digit_ff, shown_digit_in;

   logic [SecondsWidth-1:0] limit;
   logic [TickWidth-1:0]    tick_inc;
   logic [SecondsWidth-1:0] tick_seconds;
   digit_sel_type           next_pos;
   logic [SegWidth-1:0]     digit_seg;

   ect_digits u_digits (
      .value    (seconds_in),
      .pos      (next_pos),
      .segments (digit_seg)
   );

   always_comb begin
      ticks_per_second_in = ticks_per_second_ff;
      max_seconds_in      = max_seconds_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND: ticks_per_second_in = csr_wdata;
            CSR_MAX_SECONDS:      max_seconds_in = csr_wdata[SecondsWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      limit    = (max_seconds_ff > SECONDS_CAP) ? SECONDS_CAP : max_seconds_ff;
      tick_inc = tick_count_ff + 1'b1;
      tick_seconds = (seconds_ff != '0) ? seconds_ff - 1'b1 : seconds_ff;

      seconds_in     = seconds_ff;
      running_in     = running_ff;
      tick_count_in  = tick_count_ff;

      case (kind)
         KIND_UP: begin
            if (!running_ff && seconds_ff < limit) seconds_in = seconds_ff + 1'b1;
         end
         KIND_DOWN: begin
            if (!running_ff && seconds_ff != '0) seconds_in = seconds_ff - 1'b1;
         end
         KIND_START: begin
            if (seconds_ff != '0) running_in = 1'b1;
         end
         default: begin
            if (running_ff) begin
               tick_count_in = tick_inc;
               if (tick_inc >= ticks_per_second_ff) begin
                  tick_count_in = '0;
                  seconds_in    = tick_seconds;
                  if (tick_seconds == '0) running_in = 1'b0;
               end
            end
         end
      endcase

      // Next digit position, wrapping to ones and skipping blanked leading zeros.
      case (position_ff)
         DIGIT_ONES:     next_pos = (seconds_in < 10'd10) ? DIGIT_ONES : DIGIT_TENS;
         DIGIT_TENS:     next_pos = (seconds_in < 10'd100) ? DIGIT_ONES : DIGIT_HUNDREDS;
         default:        next_pos = DIGIT_ONES;
      endcase
   end

   always_comb begin
      position_in    = position_ff;
      shown_seg_in   = shown_seg_ff;
      shown_digit_in = shown_digit_ff;

      if (kind == KIND_TICK) begin
         position_in    = next_pos;
         shown_seg_in   = digit_seg;
         shown_digit_in = next_pos;
      end

      result.relay_on     = running_in;
      result.segments     = shown_seg_in;
      result.digit_enable = shown_digit_in;
      result.seconds_left = seconds_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_second_ff <= RESET_TICKS;
         max_seconds_ff      <= SECONDS_CAP;
      end else begin
         ticks_per_second_ff <= ticks_per_second_in;
         max_seconds_ff      <= max_seconds_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff     <= RESET_SECONDS;
         running_ff     <= 1'b0;
         tick_count_ff  <= '0;
         position_ff    <= DIGIT_ONES;
         shown_seg_ff   <= '0;
         shown_digit_ff <= DIGIT_NONE;
      end else if (step) begin
         seconds_ff     <= seconds_in;
         running_ff     <= running_in;
         tick_count_ff  <= tick_count_in;
         position_ff    <= position_in;
         shown_seg_ff   <= shown_seg_in;
         shown_digit_ff <= shown_digit_in;
      end
   end

endmodule

// ----- src/exposure_countdown_timer_display.sv -----
// Channel   Direction  Payload
// req_      in         tdata[1:0] event_kind
// rsp_      out        tdata[0] relay_on, [7:1] segments, [9:8] digit_enable,
//                      [19:10] seconds_left
// csr_      in         we, index (0 ticks_per_second, 1 max_seconds), wdata
//
// One request per cycle sustained while rsp_tready is high; a request passes through
// the request register, the combinational state update and the response register.
// Synchronous reset restores timer state and settings and clears both valid flags.
// When rsp_tready is low the response holds and one more request is buffered.
module exposure_countdown_timer_display (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ect_pkg::ReqDataWidth-1:0] req_tdata,  // [1:0] event_kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] relay_on, [7:1] segments, [9:8] digit_enable, [19:10] seconds_left
   output logic [ect_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [ect_pkg::CsrDataWidth-1:0] csr_wdata
);
   import ect_pkg::*;

   logic           req_valid_ff, req_valid_in;
   event_kind_type req_kind_ff, req_kind_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_data_ff, rsp_data_in;
   logic           advance;
   result_type     result;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   ect_state u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .kind      (req_kind_ff),
      .result    (result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      req_kind_in  = req_kind_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
         req_kind_in  = event_kind_type'(req_tdata[KindWidth-1:0]);
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_kind_ff <= req_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.seconds_left,
                        rsp_data_ff.digit_enable,
                        rsp_data_ff.segments,
                        rsp_data_ff.relay_on};

endmodule

// ----- tb/exposure_timer_checker.sv -----
module exposure_timer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [ect_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ect_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [ect_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                mismatches,
   output int                                awaiting,
   output int                                checked,
   output int                                expiries,
   output logic [ect_pkg::SecondsWidth-1:0]  timer_seconds,
   output logic                              timer_running
);
   import ect_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                    relay;
      logic [SegWidth-1:0]     seg;
      digit_sel_type           digit;
      logic [SecondsWidth-1:0] secs;
   } panel_view_type;

   // segment patterns for 9 down to 0, A..G in bits 0..6
   localparam logic [10*SegWidth-1:0] FONT = {
      7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   logic [TickWidth-1:0]    ticks_limit;
   logic [SecondsWidth-1:0] up_limit;
   logic [SecondsWidth-1:0] secs;
   logic                    armed;
   logic [TickWidth-1:0]    tick_cnt;
   logic [1:0]              scan_pos;
   logic [SegWidth-1:0]     lit_seg;
   digit_sel_type           lit_digit;

   panel_view_type panel_queue[$];

   function automatic panel_view_type apply_event(input event_kind_type kind);
      logic [SecondsWidth-1:0] ceiling;
      logic [3:0]              value;
      panel_view_type          view;
      ceiling = (up_limit > SECONDS_CAP) ? SECONDS_CAP : up_limit;
      case (kind)
         KIND_UP: begin
            if (!armed && secs < ceiling) secs = secs + 1'b1;
         end
         KIND_DOWN: begin
            if (!armed && secs != 0) secs = secs - 1'b1;
         end
         KIND_START: begin
            if (secs != 0) armed = 1'b1;
         end
         default: begin
            if (armed) begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= ticks_limit) begin
                  tick_cnt = '0;
                  if (secs != 0) secs = secs - 1'b1;
                  if (secs == 0) begin
                     armed = 1'b0;
                     expiries++;
                  end
               end
            end
            // step the scan; a leading zero falls back to the ones digit
            scan_pos = scan_pos + 1'b1;
            if (scan_pos == 2'd0 || (scan_pos == 2'd3 && secs < 100) ||
                (scan_pos == 2'd2 && secs < 10))
               scan_pos = 2'd1;
            case (scan_pos)
               2'd1:    value = 4'(secs % 10);
               2'd2:    value = 4'((secs / 10) % 10);
               default: value = 4'((secs / 100) % 10);
            endcase
            lit_seg   = FONT[value*SegWidth +: SegWidth];
            lit_digit = digit_sel_type'(scan_pos);
         end
      endcase
      view.relay = armed;
      view.seg   = lit_seg;
      view.digit = lit_digit;
      view.secs  = secs;
      return view;
   endfunction

   always @(posedge clock) begin : monitor
      panel_view_type seen;
      panel_view_type want;
      if (reset) begin
         ticks_limit = RESET_TICKS;
         up_limit    = SECONDS_CAP;
         secs        = RESET_SECONDS;
         armed       = 1'b0;
         tick_cnt    = '0;
         scan_pos    = 2'd1;
         lit_seg     = '0;
         lit_digit   = DIGIT_NONE;
         mismatches  = 0;
         checked     = 0;
         expiries    = 0;
         panel_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.relay = rsp_tdata[0];
            seen.seg   = rsp_tdata[7:1];
            seen.digit = digit_sel_type'(rsp_tdata[9:8]);
            seen.secs  = rsp_tdata[19:10];
            checked++;
            if (panel_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response relay=%0b seg=%h digit=%0d secs=%0d",
                           $realtime, seen.relay, seen.seg, seen.digit, seen.secs);
            end else begin
               want = panel_queue.pop_front();
               if (seen.relay !== want.relay || seen.seg !== want.seg ||
                   seen.digit !== want.digit || seen.secs !== want.secs) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: response %0d mismatch: expected relay=%0b seg=%h ",
                               "digit=%0d secs=%0d, got relay=%0b seg=%h digit=%0d secs=%0d"},
                              $realtime, checked, want.relay, want.seg, want.digit,
                              want.secs, seen.relay, seen.seg, seen.digit, seen.secs);
               end
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TICKS_PER_SECOND: ticks_limit = csr_wdata;
               default:              up_limit    = csr_wdata[SecondsWidth-1:0];
            endcase
         end
         if (req_tvalid && req_tready)
            panel_queue.push_back(apply_event(event_kind_type'(req_tdata[KindWidth-1:0])));
      end
      awaiting      = panel_queue.size();
      timer_seconds = secs;
      timer_running = armed;
   end

endmodule

// ----- tb/exposure_countdown_timer_display_tb.sv -----
module exposure_countdown_timer_display_tb;
   import ect_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 700;
   localparam int SETTLE_CYCLES  = 4;
   localparam int SINK_HOLD      = 64;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;    // [1:0] event_kind
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // [0] relay_on, [7:1] segments, [9:8] digit_enable, [19:10] seconds_left
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_we;
   logic                    csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   int                      mismatches;
   int                      awaiting;
   int                      checked;
   int                      expiries;
   logic [SecondsWidth-1:0] timer_seconds;
   logic                    timer_running;

   bit quiet;
   int sink_holds_asked;
   int sink_holds_done;
   int sent;
   int settings;
   int kind_tally[4];
   int stall_cycles;

   exposure_countdown_timer_display uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   exposure_timer_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .awaiting      (awaiting),
      .checked       (checked),
      .expiries      (expiries),
      .timer_seconds (timer_seconds),
      .timer_running (timer_running)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random ready/stall bursts, plus long holds on request
   initial begin : sink_flow
      @(negedge clock);
      forever begin
         if (sink_holds_done != sink_holds_asked) begin
            sink_holds_done++;
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD) @(negedge clock);
         end else if (quiet) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request or response moved for %0d cycles", stall_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_event(input event_kind_type kind);
      if (!quiet && $urandom_range(0, 6) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataWidth'(kind);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
      kind_tally[kind]++;
   endtask

   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      settings++;
   endtask

   initial begin : stimulus
      int random_sent;
      int stop_at;
      int n;
      int r;
      bit first_phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_TICKS_PER_SECOND;
      csr_wdata  = '0;
      quiet      = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // display is dark until the first tick
      send_event(KIND_DOWN);
      send_event(KIND_UP);
      send_event(KIND_START);
      // buttons are locked out while running
      send_event(KIND_UP);
      send_event(KIND_DOWN);
      send_event(KIND_TICK);
      send_event(KIND_TICK);
      send_event(KIND_TICK);
      send_event(KIND_START);
      sink_holds_asked++;
      repeat (6) send_event(KIND_TICK);
      settle(SETTLE_CYCLES);
      // zero tick limit: every tick takes a second off, runs down to expiry
      write_reg(CSR_TICKS_PER_SECOND, 16'd0);
      while (timer_running) send_event(KIND_TICK);
      send_event(KIND_DOWN);
      send_event(KIND_START);
      send_event(KIND_TICK);
      settle(SETTLE_CYCLES);
      write_reg(CSR_MAX_SECONDS, 16'd3);
      repeat (4) send_event(KIND_UP);
      settle(SETTLE_CYCLES);
      write_reg(CSR_MAX_SECONDS, 16'd0);
      send_event(KIND_UP);
      send_event(KIND_TICK);
      settle(SETTLE_CYCLES);
      write_reg(CSR_MAX_SECONDS, 16'd1023);
      send_event(KIND_UP);
      settle(SETTLE_CYCLES);
      write_reg(CSR_TICKS_PER_SECOND, 16'd50);
      send_event(KIND_START);
      repeat (5) send_event(KIND_TICK);
      settle(SETTLE_CYCLES);
      // limit dropped below the running count
      write_reg(CSR_TICKS_PER_SECOND, 16'd3);
      repeat (3) send_event(KIND_TICK);

      random_sent = 0;
      first_phase = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         settle(SETTLE_CYCLES);
         if (first_phase || $urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 9);
            case (r)
               0:       write_reg(CSR_TICKS_PER_SECOND, 16'd0);
               6:       write_reg(CSR_TICKS_PER_SECOND, 16'($urandom_range(5, 20)));
               7:       write_reg(CSR_TICKS_PER_SECOND, 16'hFFFF);
               8:       write_reg(CSR_TICKS_PER_SECOND, 16'($urandom_range(1, 65535)));
               9:       write_reg(CSR_TICKS_PER_SECOND, 16'd1);
               default: write_reg(CSR_TICKS_PER_SECOND, 16'($urandom_range(1, 4)));
            endcase
         end
         if (first_phase || $urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 9);
            case (r)
               4:       write_reg(CSR_MAX_SECONDS, 16'd0);
               5:       write_reg(CSR_MAX_SECONDS, 16'd999);
               6:       write_reg(CSR_MAX_SECONDS, 16'd1023);
               7:       write_reg(CSR_MAX_SECONDS, 16'($urandom_range(1000, 1023)));
               8:       write_reg(CSR_MAX_SECONDS, 16'($urandom_range(0, 1023)));
               9:       write_reg(CSR_MAX_SECONDS, 16'($urandom_range(1, 9)));
               default: write_reg(CSR_MAX_SECONDS, 16'($urandom_range(0, 40)));
            endcase
         end
         stop_at = sent + $urandom_range(40, 120);
         while (sent < stop_at) begin
            if (first_phase || $urandom_range(0, 24) == 0)
               sink_holds_asked++;
            if (first_phase || $urandom_range(0, 24) == 0)
               settle(0);
            first_phase = 1'b0;
            n = sent;
            r = $urandom_range(0, 9);
            if (r < 2) begin
               repeat ($urandom_range(1, 6))
                  send_event(event_kind_type'($urandom_range(0, 3)));
            end else if (!timer_running) begin
               // set up a time, then arm it
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 3) == 0)
                     send_event(KIND_TICK);
                  else if (timer_seconds == 0 || $urandom_range(0, 2) != 0)
                     send_event(KIND_UP);
                  else
                     send_event(KIND_DOWN);
               end
               send_event(KIND_START);
            end else begin
               repeat ($urandom_range(1, 24)) begin
                  if ($urandom_range(0, 9) == 0)
                     send_event(event_kind_type'($urandom_range(1, 3)));
                  else
                     send_event(KIND_TICK);
               end
            end
            random_sent += sent - n;
         end
      end

      // climb to the top of the range with the display scanning all digits
      settle(SETTLE_CYCLES);
      if (timer_running) begin
         write_reg(CSR_TICKS_PER_SECOND, 16'd0);
         while (timer_running) send_event(KIND_TICK);
         settle(SETTLE_CYCLES);
      end
      write_reg(CSR_MAX_SECONDS, 16'd1023);
      while (timer_seconds < SECONDS_CAP) begin
         if (timer_seconds >= 880) quiet = 1'b1;
         send_event(($urandom_range(0, 7) == 0) ? KIND_TICK : KIND_UP);
      end
      quiet = 1'b1;
      repeat (3) send_event(KIND_UP);
      repeat (3) send_event(KIND_TICK);
      settle(SETTLE_CYCLES);
      write_reg(CSR_MAX_SECONDS, 16'd999);
      send_event(KIND_UP);
      settle(SETTLE_CYCLES);
      write_reg(CSR_TICKS_PER_SECOND, 16'd1);
      send_event(KIND_START);
      repeat (6) send_event(KIND_TICK);

      settle(10);
      $display("Covered %0d requests (tick %0d, up %0d, down %0d, start %0d) over %0d writes.",
               sent, kind_tally[KIND_TICK], kind_tally[KIND_UP], kind_tally[KIND_DOWN],
               kind_tally[KIND_START], settings);
      $display("Checked %0d responses; countdown expired %0d times; %0d mismatches.",
               checked, expiries, mismatches);
      if (mismatches == 0 && awaiting == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
